### src/mcif_pkg.sv
// Shared package for the multichannel IIR filter unit: default sizes, field widths,
// request codes, the microcode word format with its program ROM, and arithmetic helpers.
// No dependencies.
package mcif_pkg;

  localparam int TAPS_DEF     = 9;
  localparam int CHANNELS_DEF = 16;

  localparam int XW = 24;  // sample and output width (Q23)
  localparam int BW = 32;  // coefficient width (Q8.24)
  localparam int ZW = 48;  // delay-state width (Q24.24)
  localparam int PW = 56;  // exact coefficient by sample product

  // Request kinds carried in tuser.
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_LOAD_A = 2'd2;
  localparam logic [1:0] REQ_STATE  = 2'd3;

  typedef logic [2:0] upc_t;

  // Program addresses.
  localparam upc_t PC_CLEAR = 3'd0;
  localparam upc_t PC_IDLE  = 3'd1;
  localparam upc_t PC_MUL0  = 3'd2;
  localparam upc_t PC_Y     = 3'd3;
  localparam upc_t PC_MULK  = 3'd4;
  localparam upc_t PC_UPD   = 3'd5;
  localparam upc_t PC_EMIT  = 3'd6;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_MUL0,
    OP_Y,
    OP_MULK,
    OP_UPD,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_CLR_DONE,
    C_SAMPLE,
    C_LAST_TAP,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  t_pc;  // next step when the condition holds
    upc_t  f_pc;  // next step otherwise
  } ucode_t;

  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t w;
    unique case (pc)
      PC_CLEAR: w = '{OP_CLEAR,  C_CLR_DONE, PC_IDLE, PC_CLEAR};
      PC_IDLE:  w = '{OP_ACCEPT, C_SAMPLE,   PC_MUL0, PC_IDLE};
      PC_MUL0:  w = '{OP_MUL0,   C_ALWAYS,   PC_Y,    PC_Y};
      PC_Y:     w = '{OP_Y,      C_ALWAYS,   PC_MULK, PC_MULK};
      PC_MULK:  w = '{OP_MULK,   C_ALWAYS,   PC_UPD,  PC_UPD};
      PC_UPD:   w = '{OP_UPD,    C_LAST_TAP, PC_EMIT, PC_MULK};
      PC_EMIT:  w = '{OP_EMIT,   C_OUT_FREE, PC_IDLE, PC_EMIT};
      default:  w = '{OP_NONE,   C_ALWAYS,   PC_IDLE, PC_IDLE};
    endcase
    return w;
  endfunction

  // Saturate a 49-bit value to the 24-bit sample range.
  function automatic logic signed [XW-1:0] sat24(input logic signed [ZW:0] v);
    logic signed [XW-1:0] r;
    if (v > 49'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -49'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[XW-1:0];
    end
    return r;
  endfunction

  // Saturate a 49-bit value to the 48-bit state range.
  function automatic logic signed [ZW-1:0] sat48(input logic signed [ZW:0] v);
    logic signed [ZW-1:0] r;
    if (v[ZW] != v[ZW-1]) begin
      r = v[ZW] ? {1'b1, {(ZW-1){1'b0}}} : {1'b0, {(ZW-1){1'b1}}};
    end else begin
      r = v[ZW-1:0];
    end
    return r;
  endfunction

  // Round a Q.47 value to Q.24, ties going up.
  function automatic logic signed [33:0] round_q47(input logic signed [PW:0] p);
    logic signed [PW:0] t;
    t = p + 57'sd4194304;
    return t[PW:23];
  endfunction

endpackage

### src/mcif_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-channel delay state of the filter unit; no package dependency.
module mcif_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/multichannel_iir_filter_unit.sv
// Top level of the multichannel IIR filter unit (transposed direct form II, fixed point).
// Depends on mcif_pkg and on mcif_ram, which holds the per-channel delay state.
//
// Usage. Requests arrive on the s_axis channel; tuser gives the kind of transaction
// (sample, feedforward coefficient load, feedback coefficient load, delay word load).
// Loads are taken in the idle step and give no result. A sample of a channel
// below CHANNELS is filtered and one result leaves on the m_axis channel carrying the
// channel number and the saturated Q23 output; samples of other channels are dropped.
// All channels share one coefficient set and each channel has its own delay line.
// Sequence: after the accepting edge a sample holds the sequencer for the steps b0*x,
// then y, then a multiply and an update step per later tap (the delay RAM has one
// registered read port), then the emit step that loads the output register. The next
// request is taken in the idle step after a free emit step. Loads are accepted at one
// transaction per cycle while the sequencer is idle.
// Reset: coefficients clear at once; the delay RAM is then swept to zero, one word a
// cycle, over all 2^(ceil(log2 CHANNELS) + ceil(log2 TAPS)) words (256 by default),
// during which s_axis_tready stays low.
// Stalls: the output register holds its result until taken. The next request is
// accepted meanwhile; a second sample runs to its emit step and waits there.
module multichannel_iir_filter_unit #(
  parameter int TAPS     = mcif_pkg::TAPS_DEF,
  parameter int CHANNELS = mcif_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // channel[3:0], coef_index[7:4], value[55:8]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // out_channel[3:0], filtered_sample[27:4], zero
);

  import mcif_pkg::*;

  localparam int KW  = $clog2(TAPS);
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW  = CHW + KW;
  localparam int DEPTH = 1 << AW;

  // Request fields.
  logic [1:0]           req_type;
  logic [3:0]           in_channel;
  logic [3:0]           in_index;
  logic signed [ZW-1:0] in_value;

  assign req_type   = s_axis_tuser;
  assign in_channel = s_axis_tdata[3:0];
  assign in_index   = s_axis_tdata[7:4];
  assign in_value   = s_axis_tdata[55:8];

  // Sequencer and datapath registers.
  upc_t                 pc;
  upc_t                 pc_next;
  logic [AW-1:0]        clr_addr;
  logic signed [BW-1:0] ff_coef [TAPS];
  logic signed [BW-1:0] fb_coef [TAPS];
  logic [3:0]           chan;
  logic signed [XW-1:0] x_reg;
  logic signed [XW-1:0] y_reg;
  logic signed [PW-1:0] prod_b;
  logic signed [PW-1:0] prod_a;
  logic [KW-1:0]        k;
  logic                 out_valid;
  logic [3:0]           out_chan;
  logic signed [XW-1:0] out_sample;

  ucode_t uw;
  logic   accept;
  logic   ch_ok;
  logic   cond_true;
  logic   out_free;
  logic   last_tap;

  // Delay RAM ports.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ZW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic signed [ZW-1:0] ram_rdata;

  // Arithmetic.
  logic signed [XW-1:0] x_sat;
  logic signed [BW-1:0] b_sel;
  logic signed [PW-1:0] mul_b;
  logic signed [PW-1:0] mul_a;
  logic signed [ZW:0]   y_acc;
  logic signed [ZW:0]   y_half;
  logic signed [XW-1:0] y_new;
  logic signed [PW:0]   diff;
  logic signed [ZW-1:0] z_next;
  logic signed [ZW:0]   z_sum;
  logic signed [ZW-1:0] z_new;

  assign uw            = ucode_rom(pc);
  assign s_axis_tready = (uw.op == OP_ACCEPT);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ch_ok         = 32'(in_channel) < CHANNELS;
  assign out_free      = !out_valid || m_axis_tready;
  assign last_tap      = (k == KW'(TAPS - 1));

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_CLR_DONE: cond_true = (clr_addr == {AW{1'b1}});
      C_SAMPLE:   cond_true = accept && (req_type == REQ_SAMPLE) && ch_ok;
      C_LAST_TAP: cond_true = last_tap;
      C_OUT_FREE: cond_true = out_free;
      default:    cond_true = 1'b1;
    endcase
    pc_next = cond_true ? uw.t_pc : uw.f_pc;
  end

  // Input sample is saturated to 24 bits before use.
  assign x_sat = sat24((ZW+1)'(in_value));

  // b0 in the first multiply step, b[k] afterwards; a[k] only for the tap updates.
  assign b_sel = (uw.op == OP_MUL0) ? ff_coef[0] : ff_coef[k];
  assign mul_b = b_sel * x_reg;
  assign mul_a = fb_coef[k] * y_reg;

  // y = round(b0*x) + z0, halved with rounding to Q23 and saturated.
  assign y_acc  = (ZW+1)'(round_q47((PW+1)'(prod_b))) + (ZW+1)'(ram_rdata);
  assign y_half = (y_acc + 49'sd1) >>> 1;
  assign y_new  = sat24(y_half);

  // z[k-1] = round(b[k]*x - a[k]*y) + z[k], with z[TAPS-1] taken as zero.
  assign diff   = (PW+1)'(prod_b) - (PW+1)'(prod_a);
  assign z_next = last_tap ? '0 : ram_rdata;
  assign z_sum  = (ZW+1)'(round_q47(diff)) + (ZW+1)'(z_next);
  assign z_new  = sat48(z_sum);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_raddr = {CHW'(chan), k};
    unique case (uw.op)
      OP_CLEAR: begin
        ram_we = 1'b1;
      end
      OP_ACCEPT: begin
        ram_we    = accept && (req_type == REQ_STATE) && ch_ok
                    && (32'(in_index) < TAPS - 1);
        ram_waddr = {CHW'(in_channel), KW'(in_index)};
        ram_wdata = in_value;
      end
      OP_MUL0: begin
        ram_raddr = {CHW'(chan), KW'(0)};
      end
      OP_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = {CHW'(chan), k - KW'(1)};
        ram_wdata = z_new;
      end
      default: begin
      end
    endcase
  end

  mcif_ram #(
    .WIDTH(ZW),
    .DEPTH(DEPTH)
  ) u_zram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        ff_coef[i] <= '0;
        fb_coef[i] <= '0;
      end
    end else begin
      pc <= pc_next;
      // The output register fills in a free emit step and empties when taken.
      if ((uw.op == OP_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (uw.op)
        OP_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
        end
        OP_ACCEPT: begin
          chan  <= in_channel;
          x_reg <= x_sat;
          if (accept && ch_ok && (32'(in_index) < TAPS)) begin
            if (req_type == REQ_LOAD_B) begin
              ff_coef[KW'(in_index)] <= in_value[BW-1:0];
            end
            if (req_type == REQ_LOAD_A) begin
              fb_coef[KW'(in_index)] <= in_value[BW-1:0];
            end
          end
        end
        OP_MUL0: begin
          prod_b <= mul_b;
        end
        OP_Y: begin
          y_reg <= y_new;
          k     <= KW'(1);
        end
        OP_MULK: begin
          prod_b <= mul_b;
          prod_a <= mul_a;
        end
        OP_UPD: begin
          k <= k + KW'(1);
        end
        OP_EMIT: begin
          if (out_free) begin
            out_chan   <= chan;
            out_sample <= y_reg;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_sample, out_chan};

  // The tap counter stays within the delay line whenever a state word is updated.
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (uw.op == OP_UPD) |-> (k != '0) && (32'(k) <= TAPS - 1))
    else $error("tap counter out of range during update");

  // An update writes the word one below the tap being read.
  a_upd_addr: assert property (@(posedge clk) disable iff (rst)
    (uw.op == OP_UPD) |-> ram_we && (ram_waddr[KW-1:0] == k - KW'(1)))
    else $error("state update written to the wrong tap");

  // No request is taken while the delay RAM is being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_CLEAR) |-> !s_axis_tready)
    else $error("request accepted during clearing pass");

  // An emit step with a free output register presents the result next cycle.
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (uw.op == OP_EMIT) && out_free |=> m_axis_tvalid && (pc == PC_IDLE))
    else $error("result not presented after emit");

endmodule

### bench/tb_multichannel_iir_filter_unit.sv
// Self-checking bench for the multichannel IIR filter unit: requests stream in through a
// bursty driver, results are checked against a bit-exact predictor of the filter.
// Depends on mcif_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_multichannel_iir_filter_unit;
  import mcif_pkg::*;

  localparam int TAPS           = TAPS_DEF;
  localparam int CHANS          = CHANNELS_DEF;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int DRAIN_EVERY    = 400;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  chan;
    logic [3:0]  idx;
    logic [47:0] value;
    bit          drain;  // not a request: hold the sender until all results are in
  } req_t;

  typedef struct packed {
    logic [3:0]  chan;
    logic [23:0] y;
  } result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_LONG_STALL
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // channel[3:0], coef_index[7:4], value[55:8]
  logic [1:0]  s_axis_tuser = '0;  // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // out_channel[3:0], filtered_sample[27:4], zero

  // Predictor state: shared coefficient set and one delay line per channel.
  int     ff_b [TAPS];
  int     fb_a [TAPS];
  longint dly  [CHANS][TAPS-1];

  req_t        req_q[$];
  result_t     y_due[$];
  req_t        cur_req;
  int unsigned items_queued   = 0;
  int unsigned accepted_items = 0;
  int unsigned mismatches     = 0;
  int          burst_left     = 8;
  int          gap_left       = 0;
  int          stall_left     = 0;
  int unsigned rx_cycles      = 0;
  int unsigned idle_cycles    = 0;

  multichannel_iir_filter_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Q.47 product down to Q.24, rounding to nearest with ties going up.
  function automatic longint q47_to_q24(longint p);
    return (p + (longint'(1) <<< 22)) >>> 23;
  endfunction

  // Applies one accepted request to the predictor and records the result it causes.
  function automatic void apply_request(req_t r);
    longint  v;
    longint  x;
    longint  y;
    longint  acc;
    longint  d;
    longint  nxt;
    result_t res;
    v = $signed(r.value);
    if (r.chan >= CHANS) return;
    case (r.kind)
      REQ_LOAD_B: if (r.idx < TAPS) ff_b[r.idx] = $signed(r.value[31:0]);
      REQ_LOAD_A: if (r.idx < TAPS) fb_a[r.idx] = $signed(r.value[31:0]);
      REQ_STATE:  if (r.idx < TAPS - 1) dly[r.chan][r.idx] = v;
      default: begin
        x   = clamp(v, 24);
        acc = q47_to_q24(longint'(ff_b[0]) * x) + dly[r.chan][0];
        y   = clamp((acc + 1) >>> 1, 24);
        for (int k = 1; k < TAPS; k++) begin
          nxt = 0;
          if (k < TAPS - 1) nxt = dly[r.chan][k];
          d = longint'(ff_b[k]) * x - longint'(fb_a[k]) * y;
          dly[r.chan][k-1] = clamp(q47_to_q24(d) + nxt, 48);
        end
        res.chan = r.chan;
        res.y    = y[23:0];
        y_due.push_back(res);
      end
    endcase
  endfunction

  task automatic queue_req(logic [1:0] kind, logic [3:0] chan, logic [3:0] idx,
                           logic [47:0] value);
    req_t r;
    r.kind  = kind;
    r.chan  = chan;
    r.idx   = idx;
    r.value = value;
    r.drain = 1'b0;
    req_q.push_back(r);
    items_queued++;
  endtask

  task automatic queue_drain();
    req_t r;
    r = '{kind: REQ_SAMPLE, chan: '0, idx: '0, value: '0, drain: 1'b1};
    req_q.push_back(r);
  endtask

  // Random signed value spanning the given number of bits, sign-extended to 48.
  function automatic logic [47:0] rand_span(int unsigned bits);
    longint r;
    r = {$urandom, $urandom};
    r = r >>> (64 - bits);
    return r[47:0];
  endfunction

  // Mostly gentle taps, so that outputs are not pinned at the rails all the time.
  function automatic logic [47:0] rand_coef();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return rand_span($urandom_range(8, 25));
    if (pick < 85) return rand_span($urandom_range(26, 32));
    return rand_span($urandom_range(33, 48));
  endfunction

  function automatic logic [47:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return rand_span($urandom_range(2, 24));
    if (pick < 95) return rand_span($urandom_range(25, 48));
    case ($urandom_range(0, 3))
      0: return 48'h0000_007F_FFFF;
      1: return 48'hFFFF_FF80_0000;
      2: return 48'h7FFF_FFFF_FFFF;
      default: return 48'h8000_0000_0000;
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps; a drain entry holds it
  // until every predicted result has been taken.
  always @(posedge clk) begin : driver
    logic hold;
    logic send;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      hold = s_axis_tvalid;
      send = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(cur_req);
        accepted_items++;
        hold = 1'b0;
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0 && req_q[0].drain) begin
          if (y_due.size() == 0) void'(req_q.pop_front());
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          send = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        s_axis_tvalid <= send;
        if (send) begin
          s_axis_tdata <= {cur_req.value, cur_req.idx, cur_req.chan};
          s_axis_tuser <= cur_req.kind;
        end else begin
          // Junk on the bus while nothing is offered.
          s_axis_tdata <= 56'({$urandom, $urandom});
          s_axis_tuser <= 2'($urandom);
        end
      end
    end
  end

  // Receiver back-pressure cycles through a few stall patterns of its own.
  always @(posedge clk) begin : receiver
    rx_mode_t mode;
    logic     take;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycles++;
      mode = rx_mode_t'(rx_cycles[9:8]);
      take = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   take = 1'b1;
          RX_COIN:   take = 1'($urandom_range(0, 1));
          RX_SPARSE: take = ($urandom_range(0, 3) == 0);
          default: begin
            if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(5, 40);
          end
        endcase
      end
      m_axis_tready <= take;
    end
  end

  task automatic note_mismatch(string field, longint want, longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %0d, got %0d", field, want, got);
  endtask

  always @(posedge clk) begin : monitor
    result_t exp_res;
    logic [3:0]  got_chan;
    logic [23:0] got_y;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_chan = m_axis_tdata[3:0];
      got_y    = m_axis_tdata[27:4];
      if (y_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no prediction: channel %0d, sample %0d",
                   got_chan, $signed(got_y));
      end else begin
        exp_res = y_due.pop_front();
        if (got_chan !== exp_res.chan) note_mismatch("out_channel", exp_res.chan, got_chan);
        if (got_y !== exp_res.y)
          note_mismatch("filtered_sample", $signed(exp_res.y), $signed(got_y));
      end
    end
  end

  // Ends the run if no transaction completes on either side for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("FAIL multichannel_iir_filter_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned roll;
    int unsigned directed_n;
    int unsigned next_drain;
    int unsigned run_len;
    logic [3:0]  ch;

    foreach (ff_b[i]) begin
      ff_b[i] = 0;
      fb_a[i] = 0;
    end
    foreach (dly[c, i]) dly[c][i] = 0;

    // Directed part: output from the reset state, extreme and wide values,
    // ignored indices, the unused leading feedback tap and state saturation.
    queue_req(REQ_SAMPLE, 4'd0,  4'd0,  48'h0000_0012_3456);
    queue_req(REQ_LOAD_B, 4'd0,  4'd0,  48'h0000_0100_0000);
    queue_req(REQ_LOAD_B, 4'd2,  4'd9,  48'h0000_7FFF_FFFF);
    queue_req(REQ_LOAD_A, 4'd1,  4'd0,  48'hABCD_8000_0000);
    queue_req(REQ_LOAD_A, 4'd4,  4'd1,  48'h0000_7FFF_FFFF);
    queue_req(REQ_LOAD_B, 4'd5,  4'd8,  48'hFFFF_8000_0000);
    queue_req(REQ_LOAD_A, 4'd6,  4'd15, 48'h0000_0000_1234);
    queue_req(REQ_LOAD_B, 4'd7,  4'd1,  48'h5A5A_0080_0000);
    queue_req(REQ_STATE,  4'd3,  4'd0,  48'h7FFF_FFFF_FFFF);
    queue_req(REQ_STATE,  4'd3,  4'd8,  48'h0000_0000_0001);
    queue_req(REQ_SAMPLE, 4'd3,  4'd0,  48'h0000_007F_FFFF);
    queue_req(REQ_SAMPLE, 4'd3,  4'd15, 48'h8000_0000_0000);
    queue_req(REQ_SAMPLE, 4'd0,  4'd0,  48'h7FFF_FFFF_FFFF);
    queue_req(REQ_SAMPLE, 4'd15, 4'd0,  48'hFFFF_FF80_0000);
    queue_req(REQ_STATE,  4'd15, 4'd7,  48'h8000_0000_0000);
    queue_req(REQ_LOAD_B, 4'd0,  4'd2,  48'h0000_7FFF_FFFF);
    queue_req(REQ_STATE,  4'd5,  4'd1,  48'h7FFF_FFFF_FFFF);
    queue_req(REQ_STATE,  4'd5,  4'd2,  48'h7FFF_FFFF_FFFF);
    queue_req(REQ_SAMPLE, 4'd5,  4'd0,  48'h0000_007F_FFFF);
    queue_req(REQ_SAMPLE, 4'd15, 4'd0,  48'h0000_0000_0001);
    queue_req(REQ_SAMPLE, 4'd5,  4'd0,  48'hFFFF_FF80_0000);
    queue_req(REQ_STATE,  4'd9,  4'd0,  48'h0000_0000_0001);
    queue_req(REQ_SAMPLE, 4'd9,  4'd0,  48'h0000_0000_0000);
    queue_drain();
    directed_n = items_queued;

    // Random part: mostly runs of samples under freshly loaded taps and states,
    // with some single loads and raw noise in between.
    next_drain = items_queued + DRAIN_EVERY;
    while (items_queued < directed_n + RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        for (int i = 0; i < TAPS; i++) begin
          queue_req(REQ_LOAD_B, 4'($urandom), 4'(i), rand_coef());
          queue_req(REQ_LOAD_A, 4'($urandom), 4'(i), rand_coef());
        end
      end else if (roll < 14) begin
        queue_req(($urandom_range(0, 1) == 0) ? REQ_LOAD_B : REQ_LOAD_A, 4'($urandom),
                  4'($urandom_range(0, 15)), rand_coef());
      end else if (roll < 22) begin
        queue_req(REQ_STATE, 4'($urandom), 4'($urandom_range(0, 15)),
                  rand_span($urandom_range(4, 48)));
      end else if (roll < 30) begin
        queue_req(2'($urandom), 4'($urandom), 4'($urandom), 48'({$urandom, $urandom}));
      end else begin
        run_len = $urandom_range(1, 12);
        ch = 4'($urandom);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 2) == 0) ch = 4'($urandom);
          queue_req(REQ_SAMPLE, ch, 4'($urandom), rand_sample());
        end
      end
      if (items_queued >= next_drain) begin
        queue_drain();
        next_drain += DRAIN_EVERY;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (accepted_items < items_queued) @(posedge clk);
    while (y_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += y_due.size();

    if (mismatches == 0) begin
      $display("PASS multichannel_iir_filter_unit");
    end else begin
      $display("FAIL multichannel_iir_filter_unit");
    end
    $finish;
  end

endmodule
